/* sv/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check, held off while reset is asserted
`define XPD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// concurrent check that also holds during reset
`define XPD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* sv/xpd_pkg.sv */
`default_nettype none

package xpd_pkg;

    // payload length of one packet
    localparam int PAYLOAD_BYTES = 8;
    localparam int ADDR_W        = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;

    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 2;
    localparam int INDEX_W  = 3;
    localparam int CFG_IDX_W = 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PREAMBLE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_POSTAMBLE = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_GOOD     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_CSUM_ERR = 2'd1;
    localparam logic [STATUS_W-1:0] ST_POST_ERR = 2'd2;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(PAYLOAD_BYTES - 1);

    // requests from the frame parser to the packet store
    typedef struct packed {
        logic                wr_en;
        logic [ADDR_W-1:0]   wr_addr;
        logic [BYTE_W-1:0]   wr_data;
        logic                start;
        logic                err_valid;
        logic [STATUS_W-1:0] err_status;
    } t_store_cmd;

    // status of the packet store back to the parser
    typedef struct packed {
        logic busy;
        logic out_free;
    } t_store_sts;

    // payload position reported on the output, modulo 8
    function automatic logic [INDEX_W-1:0] to_index(input logic [ADDR_W-1:0] addr);
        logic [ADDR_W+INDEX_W-1:0] ext;
        ext = {{INDEX_W{1'b0}}, addr};
        return ext[INDEX_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* sv/xor_packet_deframer.sv */
// XOR checksum packet deframer.
// Input channel: one received byte per request on i_rx_byte (i_in_valid,
// o_in_stall). While idle, bytes other than the preamble are dropped. After
// the preamble, PAYLOAD_BYTES data bytes are stored, then one checksum byte
// (XOR of the data) is checked and, if it matches, one postamble byte.
// Output channel: o_status, o_data_byte, o_byte_index, o_last (o_out_valid,
// i_out_stall). A checksum or postamble mismatch gives one error result in
// the cycle after the failing byte is taken. A good packet gives
// PAYLOAD_BYTES results, each read from the payload memory into its read
// register and then moved to the output register; no new read is issued
// while one is pending or the output is held. The last result carries o_last.
// Throughput: one byte per cycle outside of a payload burst; during the
// burst the input is stalled.
// A stalled output holds its result; the input then stalls too.
// Configuration: i_cfg_we writes the preamble (index 0) or postamble
// (index 1) byte, effective from the next byte.
// Reset (synchronous, active low) returns to idle with both registers zero.
`default_nettype none

module xor_packet_deframer (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic [xpd_pkg::BYTE_W-1:0]     i_rx_byte,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic [xpd_pkg::STATUS_W-1:0]        o_status,
    output logic [xpd_pkg::BYTE_W-1:0]          o_data_byte,
    output logic [xpd_pkg::INDEX_W-1:0]         o_byte_index,
    output logic                                o_last,
    input  wire logic                           i_cfg_we,
    input  wire logic [xpd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [xpd_pkg::BYTE_W-1:0]     i_cfg_data
);
    import xpd_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_DATA = 4'b0010,
        PH_CSUM = 4'b0100,
        PH_POST = 4'b1000
    } t_phase;

    t_phase            r_phase, n_phase;
    logic [ADDR_W-1:0] r_count, n_count;
    logic [BYTE_W-1:0] r_xor, n_xor;
    logic [BYTE_W-1:0] r_preamble;
    logic [BYTE_W-1:0] r_postamble;

    t_store_cmd cmd;
    t_store_sts sts;
    logic       in_acc;

    assign o_in_stall = sts.busy || !sts.out_free;
    assign in_acc     = i_in_valid && !o_in_stall;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_preamble  <= '0;
            r_postamble <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_PREAMBLE:  r_preamble  <= i_cfg_data;
                REG_POSTAMBLE: r_postamble <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // frame parser
    always_comb begin
        n_phase        = r_phase;
        n_count        = r_count;
        n_xor          = r_xor;
        cmd.wr_en      = 1'b0;
        cmd.wr_addr    = r_count;
        cmd.wr_data    = i_rx_byte;
        cmd.start      = 1'b0;
        cmd.err_valid  = 1'b0;
        cmd.err_status = ST_CSUM_ERR;
        if (in_acc) begin
            case (r_phase)
                PH_IDLE: begin
                    if (i_rx_byte == r_preamble) begin
                        n_phase = PH_DATA;
                        n_count = '0;
                        n_xor   = '0;
                    end
                end
                PH_DATA: begin
                    cmd.wr_en = 1'b1;
                    n_xor     = r_xor ^ i_rx_byte;
                    n_count   = r_count + 1'b1;
                    if (r_count == LAST_ADDR) begin
                        n_phase = PH_CSUM;
                    end
                end
                PH_CSUM: begin
                    if (i_rx_byte != r_xor) begin
                        cmd.err_valid  = 1'b1;
                        cmd.err_status = ST_CSUM_ERR;
                        n_phase        = PH_IDLE;
                    end else begin
                        n_phase = PH_POST;
                    end
                end
                PH_POST: begin
                    if (i_rx_byte != r_postamble) begin
                        cmd.err_valid  = 1'b1;
                        cmd.err_status = ST_POST_ERR;
                    end else begin
                        cmd.start = 1'b1;
                    end
                    n_phase = PH_IDLE;
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_count <= '0;
            r_xor   <= '0;
        end else begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_xor   <= n_xor;
        end
    end

    // payload memory, burst reader and output register
    xpd_store u_store (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_status     (o_status),
        .o_data_byte  (o_data_byte),
        .o_byte_index (o_byte_index),
        .o_last       (o_last)
    );

endmodule

`default_nettype wire

/* sv/xpd_store.sv */
`default_nettype none

module xpd_store (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire xpd_pkg::t_store_cmd           i_cmd,
    output xpd_pkg::t_store_sts                o_sts,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [xpd_pkg::STATUS_W-1:0]       o_status,
    output logic [xpd_pkg::BYTE_W-1:0]         o_data_byte,
    output logic [xpd_pkg::INDEX_W-1:0]        o_byte_index,
    output logic                               o_last
);
    import xpd_pkg::*;

    `include "assert_macros.svh"

    // payload memory, one write and one registered read port
    logic [BYTE_W-1:0] r_mem [PAYLOAD_BYTES];
    logic [BYTE_W-1:0] r_rd_data;

    logic              r_emit_active;
    logic [ADDR_W-1:0] r_rd_addr;
    logic              r_rd_pend;
    logic [ADDR_W-1:0] r_rd_idx;
    logic              r_rd_last;

    logic                r_out_valid;
    logic [STATUS_W-1:0] r_status;
    logic [BYTE_W-1:0]   r_data;
    logic [INDEX_W-1:0]  r_index;
    logic                r_last;

    logic out_free;
    logic rd_issue;

    assign out_free = !r_out_valid || !i_out_stall;
    assign rd_issue = r_emit_active && !r_rd_pend && out_free;

    assign o_sts.busy     = r_emit_active || r_rd_pend;
    assign o_sts.out_free = out_free;

    // memory write and read
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_cmd.wr_addr] <= i_cmd.wr_data;
        end
        if (rd_issue) begin
            r_rd_data <= r_mem[r_rd_addr];
        end
    end

    // burst read sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emit_active <= 1'b0;
            r_rd_addr     <= '0;
            r_rd_pend     <= 1'b0;
        end else begin
            r_rd_pend <= rd_issue;
            if (i_cmd.start) begin
                r_emit_active <= 1'b1;
                r_rd_addr     <= '0;
            end else if (rd_issue) begin
                r_rd_addr <= r_rd_addr + 1'b1;
                if (r_rd_addr == LAST_ADDR) begin
                    r_emit_active <= 1'b0;
                end
            end
        end
    end

    // read tag travels alongside the memory data
    always_ff @(posedge i_clk) begin
        if (rd_issue) begin
            r_rd_idx  <= r_rd_addr;
            r_rd_last <= (r_rd_addr == LAST_ADDR);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_rd_pend || i_cmd.err_valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_rd_pend) begin
            r_status <= ST_GOOD;
            r_data   <= r_rd_data;
            r_index  <= to_index(r_rd_idx);
            r_last   <= r_rd_last;
        end else if (i_cmd.err_valid) begin
            r_status <= i_cmd.err_status;
            r_data   <= '0;
            r_index  <= '0;
            r_last   <= 1'b1;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_data_byte  = r_data;
    assign o_byte_index = r_index;
    assign o_last       = r_last;

    // read data never lands on a held result
    `XPD_ASSERT(a_rd_lands_free, r_rd_pend |-> !(r_out_valid && i_out_stall), "read data overwrites a held result")
    // error results only arrive while no burst is in flight
    `XPD_ASSERT(a_err_not_busy, i_cmd.err_valid |-> !(r_emit_active || r_rd_pend), "error result during burst")
    // a good result marked last carries the final payload position
    `XPD_ASSERT(a_last_index, (r_out_valid && r_status == ST_GOOD && r_last) |-> (r_index == to_index(LAST_ADDR)), "last flag on wrong payload position")

endmodule

`default_nettype wire

/* verif/tb_xor_packet_deframer.sv */
`timescale 1ns / 1ps

module tb_xor_packet_deframer;

    import xpd_pkg::*;

    localparam int TAIL_CYCLES = 2 * PAYLOAD_BYTES + 8;
    localparam int HOLD_CYCLES = 80;
    localparam int RUN_LIMIT_NS = 2_000_000;

    typedef enum logic [1:0] {RX_IDLE, RX_DATA, RX_CSUM, RX_POST} t_rx_phase;
    typedef enum int {PKT_GOOD, PKT_BAD_CSUM, PKT_BAD_POST, PKT_TRUNC} t_pkt_kind;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [BYTE_W-1:0]   data;
        logic [INDEX_W-1:0]  index;
        logic                last;
    } t_frame_result;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [BYTE_W-1:0]    i_rx_byte;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [STATUS_W-1:0]  o_status;
    logic [BYTE_W-1:0]    o_data_byte;
    logic [INDEX_W-1:0]   o_byte_index;
    logic                 o_last;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [BYTE_W-1:0]    i_cfg_data;

    xor_packet_deframer dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_rx_byte    (i_rx_byte),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_status     (o_status),
        .o_data_byte  (o_data_byte),
        .o_byte_index (o_byte_index),
        .o_last       (o_last),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data)
    );

    // deframer model state and its copy of the registers
    t_rx_phase         rx_phase;
    int unsigned       rx_count;
    logic [BYTE_W-1:0] run_xor;
    logic [BYTE_W-1:0] payload [PAYLOAD_BYTES];
    logic [BYTE_W-1:0] cfg_preamble;
    logic [BYTE_W-1:0] cfg_postamble;

    t_frame_result     frame_results_due [$];
    logic [BYTE_W-1:0] pkt_body [PAYLOAD_BYTES];

    // run bookkeeping
    int unsigned mismatches;
    int unsigned results_seen;
    int unsigned bytes_sent;
    int unsigned good_packets;
    int unsigned csum_errors;
    int unsigned post_errors;
    int unsigned settings_used;

    // traffic shaping for the sender and the receiver
    bit idle_on;
    bit hold_req;
    bit hold_active;
    int stall_cnt;

    // clock
    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    function automatic void expect_result(input logic [STATUS_W-1:0] status,
                                          input logic [BYTE_W-1:0] data,
                                          input logic [INDEX_W-1:0] index,
                                          input logic last);
        t_frame_result r;
        r.status = status;
        r.data   = data;
        r.index  = index;
        r.last   = last;
        frame_results_due.push_back(r);
    endfunction

    // advance the deframer model by one received byte
    function automatic void deframe_byte(input logic [BYTE_W-1:0] b);
        case (rx_phase)
            RX_IDLE: begin
                if (b == cfg_preamble) begin
                    run_xor  = '0;
                    rx_count = 0;
                    rx_phase = RX_DATA;
                end
            end
            RX_DATA: begin
                if (rx_count < PAYLOAD_BYTES)
                    payload[rx_count] = b;
                run_xor  = run_xor ^ b;
                rx_count = rx_count + 1;
                if (rx_count >= PAYLOAD_BYTES)
                    rx_phase = RX_CSUM;
            end
            RX_CSUM: begin
                if (b != run_xor) begin
                    expect_result(ST_CSUM_ERR, '0, '0, 1'b1);
                    csum_errors++;
                    rx_phase = RX_IDLE;
                end else begin
                    rx_phase = RX_POST;
                end
            end
            default: begin
                if (b != cfg_postamble) begin
                    expect_result(ST_POST_ERR, '0, '0, 1'b1);
                    post_errors++;
                end else begin
                    for (int i = 0; i < PAYLOAD_BYTES; i++)
                        expect_result(ST_GOOD, payload[i], INDEX_W'(i),
                                      (i == PAYLOAD_BYTES - 1));
                    good_packets++;
                end
                rx_phase = RX_IDLE;
            end
        endcase
    endfunction

    function automatic void note_failure(input string what, input t_frame_result want,
                                         input t_frame_result got);
        mismatches++;
        if (mismatches <= 10)
            $display({"%0t: %s: expected status %0d data %02h index %0d last %0b, ",
                      "got status %0d data %02h index %0d last %0b"},
                     $realtime, what, want.status, want.data, want.index, want.last,
                     got.status, got.data, got.index, got.last);
    endfunction

    // send one byte request, predict once it is taken
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int unsigned gap;
        gap = idle_on ? $urandom_range(0, 5) : 0;
        @(negedge i_clk);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (o_in_stall);
        bytes_sent++;
        deframe_byte(b);
    endtask

    // frame from pkt_body, possibly broken or cut short on purpose
    task automatic send_packet(input t_pkt_kind kind);
        logic [BYTE_W-1:0] csum;
        int unsigned       cut;
        csum = '0;
        cut  = (kind == PKT_TRUNC) ? $urandom_range(0, PAYLOAD_BYTES - 1) : PAYLOAD_BYTES;
        send_byte(cfg_preamble);
        for (int i = 0; i < cut; i++) begin
            send_byte(pkt_body[i]);
            csum = csum ^ pkt_body[i];
        end
        if (kind == PKT_TRUNC)
            return;
        if (kind == PKT_BAD_CSUM)
            csum = csum ^ BYTE_W'($urandom_range(1, 255));
        send_byte(csum);
        if (kind == PKT_BAD_CSUM)
            return;
        if (kind == PKT_BAD_POST)
            send_byte(cfg_postamble ^ BYTE_W'($urandom_range(1, 255)));
        else
            send_byte(cfg_postamble);
    endtask

    // wait until the block has nothing left in flight
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (frame_results_due.size() != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == REG_PREAMBLE)
            cfg_preamble = value;
        else
            cfg_postamble = value;
    endtask

    task automatic reconfigure(input logic [BYTE_W-1:0] pre, input logic [BYTE_W-1:0] post);
        drain_results();
        write_reg(REG_PREAMBLE, pre);
        write_reg(REG_POSTAMBLE, post);
        settings_used++;
    endtask

    // reset registers: preamble and postamble both zero
    task automatic test_reset_defaults();
        send_byte(8'hFF);
        send_byte(8'h5A);
        pkt_body = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'hFE, 8'h00, 8'hAA};
        send_packet(PKT_GOOD);
    endtask

    // checksum and postamble mismatches, preamble value inside the frame
    task automatic test_bad_frames();
        reconfigure(8'hFF, 8'h00);
        pkt_body = '{8'hFF, 8'h12, 8'h34, 8'hFF, 8'h56, 8'h78, 8'h9A, 8'hBC};
        send_packet(PKT_BAD_CSUM);
        pkt_body = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80};
        send_byte(cfg_preamble);
        for (int i = 0; i < PAYLOAD_BYTES; i++)
            send_byte(pkt_body[i]);
        send_byte(8'hFF);
        send_byte(8'hFF);
    endtask

    // receiver holds off while the sender keeps pushing frames
    task automatic test_output_backpressure();
        reconfigure(8'hC3, 8'h3C);
        idle_on  = 1'b0;
        hold_req = 1'b1;
        for (int p = 0; p < 3; p++) begin
            for (int i = 0; i < PAYLOAD_BYTES; i++)
                pkt_body[i] = BYTE_W'($urandom);
            send_packet(PKT_GOOD);
        end
        idle_on = 1'b1;
    endtask

    // mostly well formed frames with random content, some noise and breakage
    task automatic test_random_traffic();
        int unsigned       start;
        int unsigned       pick;
        logic [BYTE_W-1:0] pre;
        logic [BYTE_W-1:0] post;
        logic [BYTE_W-1:0] b;
        for (int s = 0; s < 6; s++) begin
            case (s)
                0: begin pre = 8'h00; post = 8'hFF; end
                1: begin pre = 8'hFF; post = 8'h00; end
                2: begin pre = BYTE_W'($urandom); post = pre; end
                default: begin pre = BYTE_W'($urandom); post = BYTE_W'($urandom); end
            endcase
            idle_on = (s != 3);
            reconfigure(pre, post);
            start = bytes_sent;
            while (bytes_sent - start < 22) begin
                pick = $urandom_range(0, 99);
                for (int i = 0; i < PAYLOAD_BYTES; i++)
                    pkt_body[i] = BYTE_W'($urandom);
                if (pick < 60)
                    send_packet(PKT_GOOD);
                else if (pick < 70)
                    send_packet(PKT_BAD_CSUM);
                else if (pick < 80)
                    send_packet(PKT_BAD_POST);
                else if (pick < 87)
                    send_packet(PKT_TRUNC);
                else begin
                    // idle noise, now and then any value at all
                    b = BYTE_W'($urandom);
                    if ($urandom_range(0, 3) != 0)
                        while (b == cfg_preamble) b = BYTE_W'($urandom);
                    send_byte(b);
                end
            end
        end
        idle_on = 1'b1;
    endtask

    // result checker
    initial begin : result_checker
        t_frame_result got;
        t_frame_result want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                got.status = o_status;
                got.data   = o_data_byte;
                got.index  = o_byte_index;
                got.last   = o_last;
                results_seen++;
                stall_cnt = idle_on ? $urandom_range(0, 5) : 0;
                if (frame_results_due.size() == 0) begin
                    note_failure("result with nothing pending", '0, got);
                end else begin
                    want = frame_results_due.pop_front();
                    if (got.status !== want.status || got.data !== want.data ||
                        got.index !== want.index || got.last !== want.last)
                        note_failure("result mismatch", want, got);
                end
            end
        end
    end

    // long receiver hold-off, counted here
    initial begin : hold_off
        hold_active = 1'b0;
        forever begin
            wait (hold_req);
            hold_req = 1'b0;
            @(posedge i_clk);
            hold_active = 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            hold_active = 1'b0;
        end
    end

    // receiver stall
    initial begin : out_stall_drive
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            i_out_stall <= hold_active || (stall_cnt != 0);
            if (stall_cnt != 0)
                stall_cnt--;
        end
    end

    initial begin : run_limit
        #(RUN_LIMIT_NS);
        $display("timeout with %0d results pending", frame_results_due.size());
        $display("Verification failed");
        $finish;
    end

    initial begin : main_flow
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_rx_byte     = '0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = REG_PREAMBLE;
        i_cfg_data    = '0;
        rx_phase      = RX_IDLE;
        rx_count      = 0;
        run_xor       = '0;
        cfg_preamble  = '0;
        cfg_postamble = '0;
        mismatches    = 0;
        results_seen  = 0;
        bytes_sent    = 0;
        good_packets  = 0;
        csum_errors   = 0;
        post_errors   = 0;
        settings_used = 1;
        idle_on       = 1'b1;
        hold_req      = 1'b0;
        stall_cnt     = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_bad_frames();
        test_output_backpressure();
        test_random_traffic();
        drain_results();

        $display("sent %0d bytes over %0d register settings, checked %0d results",
                 bytes_sent, settings_used, results_seen);
        $display("frames: %0d good, %0d checksum errors, %0d postamble errors",
                 good_packets, csum_errors, post_errors);
        if (mismatches == 0 && frame_results_due.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
